// File: rtl/hgs_pkg.sv
// hgs_pkg: constants, widths and helper functions for the height gradient stencil unit
// no dependencies; imported by height_gradient_stencil_unit

package hgs_pkg;

	localparam int MAX_COLS    = 1024;
	localparam int HEIGHT_BITS = 24;
	localparam int MAX_ROWS    = 1024;
	localparam int MAX_SLICES  = 64;

	localparam int COL_AW   = $clog2(MAX_COLS);
	localparam int ROW_W    = 10;
	localparam int SLICE_W  = 6;
	localparam int CNT_W    = 11;
	localparam int SCNT_W   = 7;
	localparam int DIFF_W   = HEIGHT_BITS + 1;
	localparam int SQ_W     = 2 * HEIGHT_BITS + 1;
	localparam int GSUM_W   = 49;
	localparam int GPEAK_W  = 48;
	localparam int IN_W     = ((HEIGHT_BITS + 7) / 8) * 8;
	localparam int OUT_RAW  = SLICE_W + ROW_W + COL_AW + GSUM_W + GPEAK_W;
	localparam int OUT_W    = ((OUT_RAW + 7) / 8) * 8;

	localparam logic [1:0] CFG_ROW_COUNT   = 2'd0;
	localparam logic [1:0] CFG_COL_COUNT   = 2'd1;
	localparam logic [1:0] CFG_SLICE_COUNT = 2'd2;

	localparam logic [CNT_W-1:0]  ROWS_RST   = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0]  COLS_RST   = CNT_W'(MAX_COLS);
	localparam logic [SCNT_W-1:0] SLICES_RST = SCNT_W'(1);

	function automatic logic [CNT_W-1:0] clamp_rows(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < CNT_W'(3)) r = CNT_W'(3);
		else if (v > CNT_W'(MAX_ROWS)) r = CNT_W'(MAX_ROWS);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_cols(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < CNT_W'(3)) r = CNT_W'(3);
		else if (v > CNT_W'(MAX_COLS)) r = CNT_W'(MAX_COLS);
		return r;
	endfunction

	function automatic logic [SCNT_W-1:0] clamp_slices(input logic [SCNT_W-1:0] v);
		logic [SCNT_W-1:0] r;
		r = v;
		if (v < SCNT_W'(1)) r = SCNT_W'(1);
		else if (v > SCNT_W'(MAX_SLICES)) r = SCNT_W'(MAX_SLICES);
		return r;
	endfunction

endpackage

// File: rtl/height_gradient_stencil_unit.sv
// height_gradient_stencil_unit: cross stencil squared-gradient maximum over a height grid stream
// two line buffer memories, position counters and a four-stage arithmetic pipeline
// depends on hgs_pkg
//
// Usage: heights enter on the s_ channel in row-major order (slice, row, column), one
// transfer per cell. For every interior cell (not in the first or last row or column) one
// result transfer leaves on the m_ channel carrying slice, row, column, the sum of the
// row and column maximum squared differences and the larger of the two. Border cells
// produce no transfer. Grid sizes come from the cfg_ write port (row_count, col_count,
// slice_count) and are taken clamped to their legal ranges; write them between frames.
// Throughput is one cell per cycle while s_tready is high: each cell reads the two line
// buffers once (the row above at two neighboring addresses, the row two above at one) and
// writes both back as it leaves s1. The cell below a result takes it via s1-s3 to m_tdata.
// Reset clears the counters and the pipeline and loads the default grid 1024 x 1024 x 1;
// the line buffers are not cleared, the first two rows of each slice fill them.
// When m_tready is low the output register holds its transfer; border cells still pass
// through and drop out; s_tready drops once an emitting cell waits in s3 with s1 and s2 full.

module height_gradient_stencil_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [hgs_pkg::IN_W-1:0]   s_tdata,   // height[23:0]
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [hgs_pkg::OUT_W-1:0]  m_tdata,   // slice_index, row, col, grad_sum, grad_peak
	input  logic                       cfg_we,
	input  logic [1:0]                 cfg_index,
	input  logic [hgs_pkg::CNT_W-1:0]  cfg_data
);
	import hgs_pkg::*;

	typedef logic signed [HEIGHT_BITS-1:0] height_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic [SQ_W-1:0]               sq_t;

	// configuration, stored clamped
	logic [CNT_W-1:0]  rows_q, cols_q;
	logic [SCNT_W-1:0] slices_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= ROWS_RST;
			cols_q   <= COLS_RST;
			slices_q <= SLICES_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW_COUNT:   rows_q   <= clamp_rows(cfg_data);
				CFG_COL_COUNT:   cols_q   <= clamp_cols(cfg_data);
				CFG_SLICE_COUNT: slices_q <= clamp_slices(cfg_data[SCNT_W-1:0]);
				default: ;
			endcase
		end
	end

	// handshake chain
	logic v1_s1, v2_s2, v3_s3;
	logic e1_s1, e2_s2, e3_s3;
	logic out_free, rdy1, rdy2, rdy3, acc, lv1;

	assign out_free = !m_tvalid || m_tready;
	assign rdy3     = !v3_s3 || !e3_s3 || out_free;
	assign rdy2     = !v2_s2 || rdy3;
	assign rdy1     = !v1_s1 || rdy2;
	assign s_tready = rdy1;
	assign acc      = s_tvalid && rdy1;
	assign lv1      = v1_s1 && rdy2;

	// position counters
	logic [COL_AW-1:0]  col_pos_q;
	logic [ROW_W-1:0]   row_pos_q;
	logic [SLICE_W-1:0] slice_pos_q;
	logic col_last, row_last, slice_last, emit;

	assign col_last   = ({1'b0, col_pos_q} + CNT_W'(1)) >= cols_q;
	assign row_last   = ({1'b0, row_pos_q} + CNT_W'(1)) >= rows_q;
	assign slice_last = ({1'b0, slice_pos_q} + SCNT_W'(1)) >= slices_q;
	assign emit = (row_pos_q >= ROW_W'(2)) && ({1'b0, row_pos_q} < rows_q)
		&& (col_pos_q >= COL_AW'(1)) && (({1'b0, col_pos_q} + CNT_W'(1)) < cols_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q   <= '0;
			row_pos_q   <= '0;
			slice_pos_q <= '0;
		end else if (acc) begin
			if (col_last) begin
				col_pos_q <= '0;
				if (row_last) begin
					row_pos_q   <= '0;
					slice_pos_q <= slice_last ? '0 : slice_pos_q + SLICE_W'(1);
				end else begin
					row_pos_q <= row_pos_q + ROW_W'(1);
				end
			end else begin
				col_pos_q <= col_pos_q + COL_AW'(1);
			end
		end
	end

	// line buffers
	height_t prev_mem  [MAX_COLS];
	height_t prev2_mem [MAX_COLS];

	height_t center_s1, right_s1, up_s1, h_s1, left_q;
	logic [COL_AW-1:0]  addr_s1;
	logic [SLICE_W-1:0] sl_s1, sl_s2, sl_s3;
	logic [ROW_W-1:0]   row_s1, row_s2, row_s3;
	logic [COL_AW-1:0]  col_s2, col_s3;

	always_ff @(posedge clk) begin
		if (acc) begin
			center_s1 <= prev_mem[col_pos_q];
			right_s1  <= prev_mem[col_pos_q + COL_AW'(1)];
			up_s1     <= prev2_mem[col_pos_q];
			h_s1      <= height_t'(s_tdata[HEIGHT_BITS-1:0]);
			addr_s1   <= col_pos_q;
			sl_s1     <= slice_pos_q;
			row_s1    <= row_pos_q - ROW_W'(1);
		end
		if (lv1) begin
			prev_mem[addr_s1]  <= h_s1;
			prev2_mem[addr_s1] <= center_s1;
			left_q             <= center_s1;
		end
	end

	// differences, squares, max and sum
	diff_t d_up_s2, d_dn_s2, d_l_s2, d_r_s2;
	sq_t   q_up_s3, q_dn_s3, q_l_s3, q_r_s3;
	logic signed [2*DIFF_W-1:0] p_up, p_dn, p_l, p_r;
	sq_t dx, dy, peak;
	logic [SQ_W:0] sum;

	assign p_up = d_up_s2 * d_up_s2;
	assign p_dn = d_dn_s2 * d_dn_s2;
	assign p_l  = d_l_s2 * d_l_s2;
	assign p_r  = d_r_s2 * d_r_s2;
	assign dx   = (q_up_s3 > q_dn_s3) ? q_up_s3 : q_dn_s3;
	assign dy   = (q_l_s3 > q_r_s3) ? q_l_s3 : q_r_s3;
	assign peak = (dx > dy) ? dx : dy;
	assign sum  = {1'b0, dx} + {1'b0, dy};

	always_ff @(posedge clk) begin
		if (lv1) begin
			d_up_s2 <= DIFF_W'(center_s1) - DIFF_W'(up_s1);
			d_dn_s2 <= DIFF_W'(center_s1) - DIFF_W'(h_s1);
			d_l_s2  <= DIFF_W'(center_s1) - DIFF_W'(left_q);
			d_r_s2  <= DIFF_W'(center_s1) - DIFF_W'(right_s1);
			sl_s2   <= sl_s1;
			row_s2  <= row_s1;
			col_s2  <= addr_s1;
		end
		if (v2_s2 && rdy3) begin
			q_up_s3 <= SQ_W'(p_up);
			q_dn_s3 <= SQ_W'(p_dn);
			q_l_s3  <= SQ_W'(p_l);
			q_r_s3  <= SQ_W'(p_r);
			sl_s3   <= sl_s2;
			row_s3  <= row_s2;
			col_s3  <= col_s2;
		end
		if (out_free && v3_s3 && e3_s3) begin
			m_tdata <= OUT_W'({GPEAK_W'(peak), GSUM_W'(sum), col_s3, row_s3, sl_s3});
		end
	end

	// stage valids and emit flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1    <= 1'b0;
			v2_s2    <= 1'b0;
			v3_s3    <= 1'b0;
			e1_s1    <= 1'b0;
			e2_s2    <= 1'b0;
			e3_s3    <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy1) begin
				v1_s1 <= acc;
				e1_s1 <= emit;
			end
			if (rdy2) begin
				v2_s2 <= v1_s1;
				e2_s2 <= e1_s1;
			end
			if (rdy3) begin
				v3_s3 <= v2_s2;
				e3_s3 <= e2_s2;
			end
			if (out_free) begin
				m_tvalid <= v3_s3 && e3_s3;
			end
		end
	end

	// line buffer write never lands on an address read by the cell accepted at the same edge
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && lv1) |-> (addr_s1 != col_pos_q && addr_s1 != col_pos_q + COL_AW'(1)))
		else $error("line buffer write collides with read");

	// column counter steps by one or wraps to zero
	a_col_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (col_pos_q == '0 || col_pos_q == $past(col_pos_q) + COL_AW'(1)))
		else $error("column counter skipped");

	// an emitting cell blocked by a full output register stays in the last stage
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v3_s3 && e3_s3 && !out_free) |=> (v3_s3 && e3_s3 && $stable(col_s3)))
		else $error("stalled result lost");

	// emitted cells never lie on the first row or column
	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[SLICE_W+ROW_W-1:SLICE_W] != '0
			&& m_tdata[SLICE_W+ROW_W+COL_AW-1:SLICE_W+ROW_W] != '0))
		else $error("border cell emitted");

endmodule

// File: sim/testbench.sv
// testbench for height_gradient_stencil_unit: streams height grids and checks every result
// against a local cross-stencil predictor, across several grid sizes and idle patterns
// depends on hgs_pkg and rtl/height_gradient_stencil_unit.sv

module testbench;
	import hgs_pkg::*;

	localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
	localparam int ROW_LSB  = SLICE_W;
	localparam int COL_LSB  = ROW_LSB + ROW_W;
	localparam int SUM_LSB  = COL_LSB + COL_AW;
	localparam int PEAK_LSB = SUM_LSB + GSUM_W;
	localparam logic signed [HEIGHT_BITS-1:0] H_TOP   = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
	localparam logic signed [HEIGHT_BITS-1:0] H_EMPTY = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
	localparam int SETTLE_CYCLES = 10;

	typedef struct packed {
		logic [SLICE_W-1:0] slice_index;
		logic [ROW_W-1:0]   row;
		logic [COL_AW-1:0]  col;
		logic [GSUM_W-1:0]  grad_sum;
		logic [GPEAK_W-1:0] grad_peak;
	} grad_result_t;

	typedef struct {
		logic signed [HEIGHT_BITS-1:0] h;
		bit                            typed;
		grad_result_t                  res;
	} cell_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_ROW_COUNT;
	logic [CNT_W-1:0] cfg_data = '0;

	height_gradient_stencil_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor state
	logic [CNT_W-1:0] grid_rows = ROWS_RST;
	logic [CNT_W-1:0] grid_cols = COLS_RST;
	logic [SCNT_W-1:0] grid_slices = SLICES_RST;
	logic signed [HEIGHT_BITS-1:0] line_above [MAX_COLS];
	logic signed [HEIGHT_BITS-1:0] line_above2 [MAX_COLS];
	int unsigned row_at = 0;
	int unsigned col_at = 0;
	int unsigned slice_at = 0;

	grad_result_t grad_expected [$];
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int fail_count = 0;
	int cells_sent = 0;
	int results_seen = 0;
	int settings_run = 0;

	function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
			input int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic longint sq_gap(input longint a, input longint b);
		longint d;
		d = a - b;
		if (d < 0) d = -d;
		return d * d;
	endfunction

	function automatic bit stencil_predict(input logic signed [HEIGHT_BITS-1:0] h,
			output grad_result_t res);
		int unsigned rows, cols, slices, r, c;
		longint center, up, lft, rgt, dx, dy;
		bit hit;
		rows = clamp_to(grid_rows, 3, MAX_ROWS);
		cols = clamp_to(grid_cols, 3, MAX_COLS);
		slices = clamp_to(grid_slices, 1, MAX_SLICES);
		r = row_at;
		c = col_at % MAX_COLS;
		hit = 1'b0;
		res = '0;
		if (r >= 2 && r < rows && c >= 1 && c + 1 < cols) begin
			center = longint'(line_above[c]);
			up = longint'(line_above2[c]);
			lft = longint'(line_above2[c-1]);
			rgt = longint'(line_above[c+1]);
			dx = sq_gap(center, up);
			if (sq_gap(center, longint'(h)) > dx) dx = sq_gap(center, longint'(h));
			dy = sq_gap(center, lft);
			if (sq_gap(center, rgt) > dy) dy = sq_gap(center, rgt);
			res.slice_index = SLICE_W'(slice_at);
			res.row = ROW_W'(r - 1);
			res.col = COL_AW'(c);
			res.grad_sum = GSUM_W'(dx + dy);
			res.grad_peak = GPEAK_W'((dx > dy) ? dx : dy);
			hit = 1'b1;
		end
		line_above2[c] = line_above[c];
		line_above[c] = h;
		if (col_at + 1 >= cols) begin
			col_at = 0;
			if (row_at + 1 >= rows) begin
				row_at = 0;
				slice_at = (slice_at + 1 >= slices) ? 0 : slice_at + 1;
			end else begin
				row_at++;
			end
		end else begin
			col_at++;
		end
		return hit;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
		fail_count++;
	endtask

	always @(negedge clk) begin
		m_tready <= (rx_idle_pct == 0) ? 1'b1 : ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin : result_check
		grad_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (grad_expected.size() == 0) begin
				report_mismatch("unexpected transfer, row", m_tdata[ROW_LSB +: ROW_W], -1);
			end else begin
				want = grad_expected.pop_front();
				if (m_tdata[0 +: SLICE_W] !== want.slice_index)
					report_mismatch("slice_index", m_tdata[0 +: SLICE_W], want.slice_index);
				if (m_tdata[ROW_LSB +: ROW_W] !== want.row)
					report_mismatch("row", m_tdata[ROW_LSB +: ROW_W], want.row);
				if (m_tdata[COL_LSB +: COL_AW] !== want.col)
					report_mismatch("col", m_tdata[COL_LSB +: COL_AW], want.col);
				if (m_tdata[SUM_LSB +: GSUM_W] !== want.grad_sum)
					report_mismatch("grad_sum", m_tdata[SUM_LSB +: GSUM_W], want.grad_sum);
				if (m_tdata[PEAK_LSB +: GPEAK_W] !== want.grad_peak)
					report_mismatch("grad_peak", m_tdata[PEAK_LSB +: GPEAK_W], want.grad_peak);
			end
		end
	end

	// entered and left at a falling edge
	task automatic push_cell(input logic signed [HEIGHT_BITS-1:0] h, input bit typed,
			input grad_result_t typed_res);
		grad_result_t res;
		bit hit;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= h;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hit = stencil_predict(h, res);
		if (typed) res = typed_res;
		if (hit || typed) grad_expected = {grad_expected, res};
		cells_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		if (grad_expected.size() != 0) begin
			s_tvalid <= 1'b0;
			while (grad_expected.size() != 0) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [CNT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_ROW_COUNT:   grid_rows = val;
			CFG_COL_COUNT:   grid_cols = val;
			CFG_SLICE_COUNT: grid_slices = val[SCNT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// only at a frame boundary, so no line buffer entry is read before it is written
	task automatic settle_and_configure(input logic [CNT_W-1:0] rows_raw,
			input logic [CNT_W-1:0] cols_raw, input logic [CNT_W-1:0] slices_raw,
			input bit poke_unused);
		s_tvalid <= 1'b0;
		while (grad_expected.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		write_reg(CFG_ROW_COUNT, rows_raw);
		write_reg(CFG_COL_COUNT, cols_raw);
		write_reg(CFG_SLICE_COUNT, slices_raw);
		if (poke_unused) write_reg(CFG_UNUSED_IDX, CNT_W'($urandom));
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	function automatic logic signed [HEIGHT_BITS-1:0] make_height(input int base);
		case ($urandom_range(9))
			0: return H_EMPTY;
			1: return H_TOP;
			2, 3, 4: return HEIGHT_BITS'($urandom);
			default: return HEIGHT_BITS'(base + int'($urandom_range(2000)) - 1000);
		endcase
	endfunction

	task automatic run_grid(input logic [CNT_W-1:0] rows_raw, input logic [CNT_W-1:0] cols_raw,
			input logic [CNT_W-1:0] slices_raw, input int frames);
		int unsigned cells;
		int unsigned pause_at;
		int base;
		settle_and_configure(rows_raw, cols_raw, slices_raw, $urandom_range(3) == 0);
		cells = clamp_to(grid_rows, 3, MAX_ROWS) * clamp_to(grid_cols, 3, MAX_COLS)
			* clamp_to(grid_slices, 1, MAX_SLICES) * frames;
		base = int'($urandom);
		pause_at = $urandom_range(cells - 1);
		for (int unsigned i = 0; i < cells; i++) begin
			if (i == pause_at) drain_results();
			push_cell(make_height(base), 1'b0, '0);
		end
	endtask

	initial begin
		#4_000_000;
		$display("testbench: FAIL");
		$finish;
	end

	initial begin : stimulus
		cell_row_t cell_table [18];
		grad_result_t peak_res;
		logic [CNT_W-1:0] rows_raw, cols_raw, slices_raw;
		for (int i = 0; i < MAX_COLS; i++) begin
			line_above[i] = '0;
			line_above2[i] = '0;
		end
		peak_res = '{slice_index: '0, row: ROW_W'(1), col: COL_AW'(1),
			grad_sum: 49'd562949886312450, grad_peak: 48'd281474943156225};
		// empty center among top-code neighbors, then a mixed frame right after the wrap
		cell_table = '{
			'{24'sd0, 1'b0, '0}, '{H_TOP, 1'b0, '0}, '{24'sd0, 1'b0, '0},
			'{H_TOP, 1'b0, '0}, '{H_EMPTY, 1'b0, '0}, '{H_TOP, 1'b0, '0},
			'{24'sd0, 1'b0, '0}, '{H_TOP, 1'b1, peak_res}, '{24'sd0, 1'b0, '0},
			'{24'sd55, 1'b0, '0}, '{24'sd100, 1'b0, '0}, '{-24'sd9, 1'b0, '0},
			'{24'sd7, 1'b0, '0}, '{24'sd0, 1'b0, '0}, '{-24'sd2000, 1'b0, '0},
			'{H_EMPTY, 1'b0, '0}, '{-24'sd300, 1'b0, '0}, '{H_TOP, 1'b0, '0}
		};
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		tx_idle_pct = 17;
		rx_idle_pct = 46;
		// below-range counts clamp up to a 3 x 3 x 1 grid
		settle_and_configure(CNT_W'(0), CNT_W'(2), CNT_W'(0), 1'b1);
		foreach (cell_table[i]) push_cell(cell_table[i].h, cell_table[i].typed, cell_table[i].res);

		// above-range slice count clamps to the deepest stack
		run_grid(CNT_W'(1), CNT_W'(0), CNT_W'(2047), 1);

		while (cells_sent < 1900) begin
			if (cells_sent < 633) begin
				tx_idle_pct = 17;
				rx_idle_pct = 46;
			end else if (cells_sent < 1266) begin
				tx_idle_pct = 46;
				rx_idle_pct = 17;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			rows_raw = ($urandom_range(5) == 0) ? CNT_W'($urandom_range(2)) :
				CNT_W'($urandom_range(8, 3));
			if ($urandom_range(7) == 0) cols_raw = CNT_W'($urandom_range(40, 9));
			else if ($urandom_range(5) == 0) cols_raw = CNT_W'($urandom_range(2));
			else cols_raw = CNT_W'($urandom_range(8, 3));
			slices_raw = ($urandom_range(5) == 0) ? CNT_W'(0) : CNT_W'($urandom_range(3, 1));
			run_grid(rows_raw, cols_raw, slices_raw, $urandom_range(2, 1));
		end

		s_tvalid <= 1'b0;
		while (grad_expected.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("summary: %0d cells streamed over %0d grid settings, %0d results checked",
			cells_sent, settings_run, results_seen);
		$display("summary: grids from 3 x 3 up to 8 rows by 40 columns, stacks up to 64 slices");
		if (fail_count == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
